// File: src/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared definitions for the sorted insert stack
// Sizes, operation and error codes, and the control word broadcast to cells.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int ERROR_WIDTH = 2;

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // error codes
  localparam logic [ERROR_WIDTH-1:0] ERR_OK    = 2'd0;
  localparam logic [ERROR_WIDTH-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERROR_WIDTH-1:0] ERR_EMPTY = 2'd2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  // control word seen by every cell in the same cycle
  typedef struct packed {
    logic   push;
    logic   pop;
    value_t value;
  } cell_ctl_t;

endpackage

// File: src/sis_if.sv
// ----------------------------------------------------------------------------
// sis_if: channel interfaces for the sorted insert stack
// Command channel (mode, value) and response channel (top, count, error).
// ----------------------------------------------------------------------------
interface sis_cmd_if;
  logic                valid;
  logic                ready;
  logic                mode;
  sis_pkg::value_t     value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface sis_rsp_if;
  logic                                 valid;
  logic                                 ready;
  sis_pkg::value_t                      top_value;
  logic                                 top_valid;
  sis_pkg::count_t                      entry_count;
  logic [sis_pkg::ERROR_WIDTH-1:0]      error;

  modport source (output valid, output top_value, output top_valid,
                  output entry_count, output error, input ready);
  modport sink   (input valid, input top_value, input top_valid,
                  input entry_count, input error, output ready);
endinterface

// File: src/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell: one entry of the sorted chain
// Holds one value. On push it keeps its value, takes the new value or takes
// the value of the cell above; on pop it takes the value of the cell below.
// ----------------------------------------------------------------------------
module sis_cell (
  input  logic               clk,
  input  sis_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               up_lt,
  input  sis_pkg::value_t    up_value,
  input  sis_pkg::value_t    down_value,
  output logic               lt,
  output sis_pkg::value_t    entry,
  output sis_pkg::value_t    entry_next
);

  // stored entry strictly smaller than the incoming word stays put
  assign lt = occupied && (entry < ctl.value);

  // select next content
  always_comb begin
    entry_next = entry;
    if (ctl.push) begin
      if (!lt) begin
        entry_next = up_lt ? ctl.value : up_value;
      end
    end else if (ctl.pop) begin
      entry_next = down_value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: src/sorted_insert_stack.sv
// ----------------------------------------------------------------------------
// sorted_insert_stack: bounded min priority queue built as a chain of cells
// Each command word pushes a signed value or pops the smallest one; every
// command returns one response word with the top value, a valid flag, the
// entry count and an error code.
//
// Channels: cmd (sink) carries mode and value, rsp (source) carries the
// response. A word moves when valid and ready are both high.
// Response: the response is registered and shows in the cycle after the command
// is accepted. Throughput: one command per cycle while no response waits or
// rsp.ready is high; every cell compares and shifts in parallel, so the count
// register and the response register set the pace, not the depth.
// Stall: while a response waits and rsp.ready is low, cmd.ready is low; it
// rises in the same cycle the waiting response is taken.
// Reset: rst clears the entry count and the response valid; cell contents
// are left as they are and are never read before being written.
// Push when full is dropped with ERR_FULL; pop when empty reports ERR_EMPTY.
// ----------------------------------------------------------------------------
module sorted_insert_stack (
  input  logic            clk,
  input  logic            rst,
  sis_cmd_if.sink         cmd,
  sis_rsp_if.source       rsp
);

  localparam int DEPTH = sis_pkg::DEPTH;

  sis_pkg::count_t    count;
  sis_pkg::count_t    count_next;
  logic               accept;
  logic               full;
  logic               empty;
  logic               do_push;
  logic               do_pop;
  sis_pkg::cell_ctl_t ctl;

  logic               rsp_valid;
  sis_pkg::value_t    rsp_top_value;
  logic               rsp_top_valid;
  sis_pkg::count_t    rsp_entry_count;
  logic [sis_pkg::ERROR_WIDTH-1:0] rsp_error;
  logic [sis_pkg::ERROR_WIDTH-1:0] error_next;

  sis_pkg::value_t    entry      [DEPTH];
  sis_pkg::value_t    entry_next [DEPTH];
  logic [DEPTH-1:0]   lt;
  logic [DEPTH-1:0]   occupied;

  // handshake and operation decode
  assign cmd.ready = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == sis_pkg::COUNT_WIDTH'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = accept && (cmd.mode == sis_pkg::MODE_PUSH) && !full;
  assign do_pop    = accept && (cmd.mode == sis_pkg::MODE_POP) && !empty;

  assign ctl.push  = do_push;
  assign ctl.pop   = do_pop;
  assign ctl.value = cmd.value;

  // count update and error code
  always_comb begin
    count_next = count;
    error_next = sis_pkg::ERR_OK;
    if (do_push) begin
      count_next = count + sis_pkg::COUNT_WIDTH'(1);
    end else if (do_pop) begin
      count_next = count - sis_pkg::COUNT_WIDTH'(1);
    end
    if (cmd.mode == sis_pkg::MODE_PUSH) begin
      if (full) begin
        error_next = sis_pkg::ERR_FULL;
      end
    end else if (empty) begin
      error_next = sis_pkg::ERR_EMPTY;
    end
  end

  // cell chain, index 0 is the top (smallest)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i] = (count > sis_pkg::COUNT_WIDTH'(i));

    if (i == 0) begin : g_top
      sis_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .up_lt      (1'b1),
        .up_value   ('0),
        .down_value ((DEPTH > 1) ? entry[(i + 1) % DEPTH] : '0),
        .lt         (lt[i]),
        .entry      (entry[i]),
        .entry_next (entry_next[i])
      );
    end else if (i == DEPTH - 1) begin : g_bottom
      sis_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .up_lt      (lt[i-1]),
        .up_value   (entry[i-1]),
        .down_value ('0),
        .lt         (lt[i]),
        .entry      (entry[i]),
        .entry_next (entry_next[i])
      );
    end else begin : g_mid
      sis_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .up_lt      (lt[i-1]),
        .up_value   (entry[i-1]),
        .down_value (entry[i+1]),
        .lt         (lt[i]),
        .entry      (entry[i]),
        .entry_next (entry_next[i])
      );
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_top_value   <= (count_next == '0) ? '0 : entry_next[0];
      rsp_top_valid   <= (count_next != '0);
      rsp_entry_count <= count_next;
      rsp_error       <= error_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.top_value   = rsp_top_value;
  assign rsp.top_valid   = rsp_top_valid;
  assign rsp.entry_count = rsp_entry_count;
  assign rsp.error       = rsp_error;

endmodule

// File: bench/sis_rsp_checker.sv
// ----------------------------------------------------------------------------
// sis_rsp_checker: response checker for the sorted insert stack
// Watches the command and response channels, keeps its own sorted copy of
// the stored values and compares every response word, field by field,
// against the oldest predicted word. Reports a running mismatch count and
// the number of responses still owed.
// ----------------------------------------------------------------------------
module sis_rsp_checker (
  input  logic clk,
  input  logic rst,
  sis_cmd_if   cmd,
  sis_rsp_if   rsp,
  output int   mismatches,
  output int   awaited
);

  typedef struct {
    sis_pkg::value_t                 top_value;
    logic                            top_valid;
    sis_pkg::count_t                 entry_count;
    logic [sis_pkg::ERROR_WIDTH-1:0] error;
  } stack_view_t;

  // mirror of the store: index 0 is the bottom (largest value)
  sis_pkg::value_t held_vals [sis_pkg::DEPTH];
  int              held_count = 0;
  stack_view_t     due_views [$];
  int              miss_total = 0;

  // apply one command to the mirror and return the view it should report
  function automatic stack_view_t sorted_push_pop(input logic op,
                                                  input sis_pkg::value_t v);
    stack_view_t view;
    int          pos;
    view.error = sis_pkg::ERR_OK;
    if (op == sis_pkg::MODE_PUSH) begin
      if (held_count >= sis_pkg::DEPTH) begin
        view.error = sis_pkg::ERR_FULL;
      end else begin
        // slide strictly smaller entries toward the top
        pos = held_count;
        while (pos > 0 && held_vals[pos-1] < v) begin
          held_vals[pos] = held_vals[pos-1];
          pos--;
        end
        held_vals[pos] = v;
        held_count++;
      end
    end else if (held_count == 0) begin
      view.error = sis_pkg::ERR_EMPTY;
    end else begin
      held_count--;
    end
    view.top_valid   = (held_count != 0);
    view.top_value   = (held_count != 0) ? held_vals[held_count-1] : '0;
    view.entry_count = sis_pkg::count_t'(held_count);
    return view;
  endfunction

  // response first, then the new command: a response never belongs to a
  // command accepted at the same edge
  always @(posedge clk) begin
    stack_view_t want;
    if (rst) begin
      due_views.delete();
      held_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_views.size() == 0) begin
          miss_total++;
          if (miss_total <= 10)
            $display("%0t: unexpected response word top=%0d valid=%0b count=%0d err=%0d",
                     $realtime, rsp.top_value, rsp.top_valid, rsp.entry_count, rsp.error);
        end else begin
          want = due_views.pop_front();
          if (rsp.top_value !== want.top_value || rsp.top_valid !== want.top_valid ||
              rsp.entry_count !== want.entry_count || rsp.error !== want.error) begin
            miss_total++;
            if (miss_total <= 10)
              $display({"%0t: mismatch exp top=%0d valid=%0b count=%0d err=%0d,",
                        " got top=%0d valid=%0b count=%0d err=%0d"},
                       $realtime, want.top_value, want.top_valid, want.entry_count,
                       want.error, rsp.top_value, rsp.top_valid, rsp.entry_count,
                       rsp.error);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        due_views.insert(due_views.size(), sorted_push_pop(cmd.mode, cmd.value));
    end
    mismatches <= miss_total;
    awaited    <= due_views.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the sorted insert stack
// Drives a directed opening (pop on empty, extreme and repeated values, fill
// to the limit and push when full) and then random bursts that lean toward
// pushes or pops so the store swings between empty and full. Runs three
// phases with different idle mixes on both channels; the checker beside the
// block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 17;
  int   recv_idle_pct = 63;
  int   failures;
  int   awaited;

  sis_cmd_if cmd_ch ();
  sis_rsp_if rsp_ch ();

  sorted_insert_stack DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  sis_rsp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .mismatches (failures),
    .awaited    (awaited)
  );

  always #5 clk = ~clk;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.mode  = sis_pkg::MODE_PUSH;
    cmd_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  // response side back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // offer one command word and hold it until taken
  task automatic send_word(input logic op, input sis_pkg::value_t v);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode  <= op;
    cmd_ch.value <= v;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // extremes and small clustered values show up often to get ties
  function automatic sis_pkg::value_t pick_value();
    case ($urandom_range(9, 0))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return sis_pkg::value_t'($signed($urandom_range(8, 0)) - 4);
      default: return sis_pkg::value_t'($urandom);
    endcase
  endfunction

  // bursts biased to push or pop so the store reaches both ends
  task automatic random_bursts(input int total);
    int left;
    int push_pct;
    int burst;
    left = total;
    while (left > 0) begin
      case ($urandom_range(2, 0))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      burst = $urandom_range(24, 4);
      while (burst > 0 && left > 0) begin
        send_word(($urandom_range(99, 0) < push_pct) ? sis_pkg::MODE_PUSH : sis_pkg::MODE_POP,
                  pick_value());
        burst--;
        left--;
      end
    end
  endtask

  // stop sending until every owed response has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: pop on empty, fill with extremes and ties, push when full
    send_word(sis_pkg::MODE_POP,  '0);
    send_word(sis_pkg::MODE_PUSH, 32'sh7fff_ffff);
    send_word(sis_pkg::MODE_PUSH, 32'sh8000_0000);
    send_word(sis_pkg::MODE_PUSH, 0);
    send_word(sis_pkg::MODE_PUSH, -1);
    send_word(sis_pkg::MODE_PUSH, 1);
    send_word(sis_pkg::MODE_PUSH, 5);
    send_word(sis_pkg::MODE_PUSH, 5);
    send_word(sis_pkg::MODE_PUSH, 5);
    send_word(sis_pkg::MODE_PUSH, -5);
    send_word(sis_pkg::MODE_PUSH, -5);
    send_word(sis_pkg::MODE_PUSH, 100);
    send_word(sis_pkg::MODE_PUSH, -100);
    send_word(sis_pkg::MODE_PUSH, 32'sh7fff_fffe);
    send_word(sis_pkg::MODE_PUSH, 32'sh8000_0001);
    send_word(sis_pkg::MODE_PUSH, 0);
    send_word(sis_pkg::MODE_PUSH, 3);
    send_word(sis_pkg::MODE_PUSH, 42);
    send_word(sis_pkg::MODE_POP,  32'sh7fff_ffff);
    send_word(sis_pkg::MODE_POP,  '0);
    send_word(sis_pkg::MODE_POP,  -1);

    random_bursts(250);
    drain();

    send_idle_pct = 63;
    recv_idle_pct = 17;
    random_bursts(250);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_bursts(250);
    drain();

    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
